// File: hdl/assert_macros.svh
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define BBSS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define BBSS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/bbss_pkg.sv
// shared types, constants and helpers of the byte buffer sort/search engine
package bbss_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int CMD_W         = 3;
   localparam int CHAR_W        = 8;
   localparam int STATUS_W      = 2;
   localparam int POS_W         = 6;

   // command codes
   localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SORT    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DUMP    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DUMP_NV = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   // which single-result response the datapath builds this cycle
   typedef enum logic [2:0] {
      RK_NONE,
      RK_DONE,
      RK_APPEND,
      RK_FOUND,
      RK_MISS,
      RK_DUMP_END
   } rsp_kind_type;

   // controller to datapath
   typedef struct packed {
      logic         load;
      logic         advance;
      logic         hold_load;
      logic         compare;
      logic         write_back;
      logic         append;
      logic         clear;
      logic         dump_take;
      logic         skip_vowels;
      rsp_kind_type rsp_kind;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fill_zero;
      logic fill_lt2;
      logic pos_last;
      logic match;
      logic more_rows;
   } dp_stat_type;

   function automatic logic is_vowel(input logic [CHAR_W-1:0] c);
      is_vowel = (c == "A") || (c == "E") || (c == "I") || (c == "O") || (c == "U") ||
                 (c == "a") || (c == "e") || (c == "i") || (c == "o") || (c == "u");
   endfunction

endpackage

// File: hdl/bbss_ram.sv
// generic single-write, single-read ram with registered read data
module bbss_ram #(
   parameter int WIDTH = bbss_pkg::CHAR_W,
   parameter int DEPTH = bbss_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/bbss_dpath.sv
// datapath: byte store, fill count, walk pointers, sort hold register, result registers
module bbss_dpath #(
   parameter int DEPTH = bbss_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bbss_pkg::dp_cmd_type            cmd,
   input  logic [bbss_pkg::CHAR_W-1:0]     req_char_in,
   output bbss_pkg::dp_stat_type           stat,
   output logic                            rsp_strobe,
   output logic [bbss_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_has_char,
   output logic [bbss_pkg::CHAR_W-1:0]     rsp_char_out,
   output logic [bbss_pkg::POS_W-1:0]      rsp_position,
   output logic                            rsp_last
);
   import bbss_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [CHAR_W-1:0]   char_ff, char_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [AW-1:0]       base_ff, base_in;
   logic [CHAR_W-1:0]   held_ff, held_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [CHAR_W-1:0]   pend_char_ff, pend_char_in;
   logic [AW-1:0]       pend_pos_ff, pend_pos_in;
   logic                strobe_ff, strobe_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                has_ff, has_in;
   logic [CHAR_W-1:0]   out_char_ff, out_char_in;
   logic [POS_W-1:0]    out_pos_ff, out_pos_in;
   logic                last_ff, last_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [CHAR_W-1:0]   wr_data;
   logic [CHAR_W-1:0]   rd_data;
   logic                full;
   logic                emit_ok;

   bbss_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign full    = (fill_ff == CW'(DEPTH));
   assign emit_ok = !(cmd.skip_vowels && is_vowel(rd_data));

   assign stat.fill_zero = (fill_ff == '0);
   assign stat.fill_lt2  = (fill_ff < CW'(2));
   assign stat.pos_last  = (CW'(pos_ff) == (fill_ff - CW'(1)));
   assign stat.match     = (rd_data == char_ff);
   assign stat.more_rows = ((CW'(base_ff) + CW'(2)) < fill_ff);

   always_comb begin
      char_in       = char_ff;
      idx_in        = idx_ff;
      pos_in        = idx_ff;   // read data always belongs to last cycle's address
      base_in       = base_ff;
      held_in       = held_ff;
      fill_in       = fill_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      pend_pos_in   = pend_pos_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = held_ff;
      strobe_in     = 1'b0;
      status_in     = ST_OK;
      has_in        = 1'b0;
      out_char_in   = '0;
      out_pos_in    = '0;
      last_in       = 1'b0;

      if (cmd.load) begin
         char_in       = req_char_in;
         idx_in        = '0;
         base_in       = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.advance) begin
         idx_in = idx_ff + AW'(1);
      end
      if (cmd.hold_load) begin
         held_in = rd_data;
      end
      // exchange step: smaller byte moves into the held slot
      if (cmd.compare && (rd_data < held_ff)) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff;
         wr_data = held_ff;
         held_in = rd_data;
      end
      if (cmd.write_back) begin
         wr_en   = 1'b1;
         wr_addr = base_ff;
         wr_data = held_ff;
         base_in = base_ff + AW'(1);
         idx_in  = base_ff + AW'(1);
      end
      if (cmd.append && !full) begin
         wr_en   = 1'b1;
         wr_addr = fill_ff[AW-1:0];
         wr_data = char_ff;
         fill_in = fill_ff + CW'(1);
      end
      if (cmd.clear) begin
         fill_in = '0;
      end

      // one-behind pending byte so the final dump result can carry last
      if (cmd.dump_take && emit_ok) begin
         if (pend_valid_ff) begin
            strobe_in   = 1'b1;
            has_in      = 1'b1;
            out_char_in = pend_char_ff;
            out_pos_in  = POS_W'(pend_pos_ff);
         end
         pend_valid_in = 1'b1;
         pend_char_in  = rd_data;
         pend_pos_in   = pos_ff;
      end

      case (cmd.rsp_kind)
         RK_NONE: begin
         end
         RK_DONE: begin
            strobe_in = 1'b1;
            last_in   = 1'b1;
         end
         RK_APPEND: begin
            strobe_in = 1'b1;
            last_in   = 1'b1;
            if (full) begin
               status_in = ST_FULL;
            end else begin
               out_pos_in = POS_W'(fill_ff);
            end
         end
         RK_FOUND: begin
            strobe_in  = 1'b1;
            last_in    = 1'b1;
            out_pos_in = POS_W'(pos_ff);
         end
         RK_MISS: begin
            strobe_in = 1'b1;
            last_in   = 1'b1;
            status_in = ST_NOT_FOUND;
         end
         RK_DUMP_END: begin
            strobe_in = 1'b1;
            last_in   = 1'b1;
            if (pend_valid_ff) begin
               has_in      = 1'b1;
               out_char_in = pend_char_ff;
               out_pos_in  = POS_W'(pend_pos_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         strobe_ff <= strobe_in;
      end
      char_ff       <= char_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      base_ff       <= base_in;
      held_ff       <= held_in;
      pend_valid_ff <= pend_valid_in;
      pend_char_ff  <= pend_char_in;
      pend_pos_ff   <= pend_pos_in;
      status_ff     <= status_in;
      has_ff        <= has_in;
      out_char_ff   <= out_char_in;
      out_pos_ff    <= out_pos_in;
      last_ff       <= last_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_status   = status_ff;
   assign rsp_has_char = has_ff;
   assign rsp_char_out = out_char_ff;
   assign rsp_position = out_pos_ff;
   assign rsp_last     = last_ff;

endmodule

// File: hdl/bbss_ctrl.sv
// controller: command sequencing state machine
module bbss_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bbss_pkg::CMD_W-1:0]   req_command,
   input  bbss_pkg::dp_stat_type        stat,
   output bbss_pkg::dp_cmd_type         cmd,
   output logic                         busy
);
   import bbss_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SORT_LOAD,
      S_SORT_HOLD,
      S_SORT_CMP,
      S_SORT_WB,
      S_SRCH_CMP,
      S_DUMP_EMIT,
      S_DUMP_END
   } state_type;

   state_type          state_ff, state_in;
   logic               busy_ff, busy_in;
   logic [CMD_W-1:0]   op_ff, op_in;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.rsp_kind    = RK_NONE;
      cmd.skip_vowels = (op_ff == CMD_DUMP_NV);

      case (state_ff)
         S_IDLE: begin
            if (start && !busy_ff) begin
               cmd.load = 1'b1;
               op_in    = req_command;
               busy_in  = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (op_ff)
               CMD_APPEND: begin
                  cmd.append   = 1'b1;
                  cmd.rsp_kind = RK_APPEND;
                  busy_in      = 1'b0;
                  state_in     = S_IDLE;
               end
               CMD_SORT: begin
                  if (stat.fill_lt2) begin
                     cmd.rsp_kind = RK_DONE;
                     busy_in      = 1'b0;
                     state_in     = S_IDLE;
                  end else begin
                     cmd.advance = 1'b1;
                     state_in    = S_SORT_HOLD;
                  end
               end
               CMD_SEARCH: begin
                  if (stat.fill_zero) begin
                     cmd.rsp_kind = RK_MISS;
                     busy_in      = 1'b0;
                     state_in     = S_IDLE;
                  end else begin
                     cmd.advance = 1'b1;
                     state_in    = S_SRCH_CMP;
                  end
               end
               CMD_DUMP, CMD_DUMP_NV: begin
                  if (stat.fill_zero) begin
                     state_in = S_DUMP_END;
                  end else begin
                     cmd.advance = 1'b1;
                     state_in    = S_DUMP_EMIT;
                  end
               end
               CMD_CLEAR: begin
                  cmd.clear    = 1'b1;
                  cmd.rsp_kind = RK_DONE;
                  busy_in      = 1'b0;
                  state_in     = S_IDLE;
               end
               default: begin
                  cmd.rsp_kind = RK_DONE;
                  busy_in      = 1'b0;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_SORT_LOAD: begin
            cmd.advance = 1'b1;
            state_in    = S_SORT_HOLD;
         end
         S_SORT_HOLD: begin
            cmd.hold_load = 1'b1;
            cmd.advance   = 1'b1;
            state_in      = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            cmd.compare = 1'b1;
            cmd.advance = 1'b1;
            if (stat.pos_last) begin
               state_in = S_SORT_WB;
            end
         end
         S_SORT_WB: begin
            cmd.write_back = 1'b1;
            if (stat.more_rows) begin
               state_in = S_SORT_LOAD;
            end else begin
               cmd.rsp_kind = RK_DONE;
               busy_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_SRCH_CMP: begin
            if (stat.match) begin
               cmd.rsp_kind = RK_FOUND;
               busy_in      = 1'b0;
               state_in     = S_IDLE;
            end else if (stat.pos_last) begin
               cmd.rsp_kind = RK_MISS;
               busy_in      = 1'b0;
               state_in     = S_IDLE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_DUMP_EMIT: begin
            cmd.dump_take = 1'b1;
            cmd.advance   = 1'b1;
            if (stat.pos_last) begin
               state_in = S_DUMP_END;
            end
         end
         S_DUMP_END: begin
            cmd.rsp_kind = RK_DUMP_END;
            busy_in      = 1'b0;
            state_in     = S_IDLE;
         end
         default: begin
            busy_in  = 1'b0;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
      op_ff <= op_in;
   end

   assign busy = busy_ff;

endmodule

// File: hdl/byte_buffer_sort_search.sv
// top level of the byte buffer engine: append, exchange sort, search, dump (all bytes or non-vowels), clear
//
//  channel   ports                                         transfer
//  --------  --------------------------------------------  --------------------------
//  request   req_command, req_char_in                      start high while busy low
//  response  rsp_status, rsp_has_char, rsp_char_out,       rsp_strobe high, one cycle
//            rsp_position, rsp_last
//
//  append, clear, unused codes: result set up in the dispatch state, then registered
//  search, dump: one entry read per cycle
//  sort of n >= 2 bytes: one compare-and-swap per cycle through the single store read port
//  reset clears the fill count and the controller; store contents are not cleared
//  results cannot be stalled; busy stays high until the last result is issued
module byte_buffer_sort_search #(
   parameter int DEPTH = bbss_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [bbss_pkg::CMD_W-1:0]      req_command,
   input  logic [bbss_pkg::CHAR_W-1:0]     req_char_in,
   output logic                            rsp_strobe,
   output logic [bbss_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_has_char,
   output logic [bbss_pkg::CHAR_W-1:0]     rsp_char_out,
   output logic [bbss_pkg::POS_W-1:0]      rsp_position,
   output logic                            rsp_last
);
   import bbss_pkg::*;

   `include "assert_macros.svh"

   // command and status buses between sequencer and datapath
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequencer: walks each command through its datapath steps
   bbss_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (dp_stat),
      .cmd         (dp_cmd),
      .busy        (busy)
   );

   // datapath: store ram, pointers, hold register and result registers
   bbss_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .req_char_in  (req_char_in),
      .stat         (dp_stat),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_has_char (rsp_has_char),
      .rsp_char_out (rsp_char_out),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_last)
   );

   // a request transfer always starts a busy period
   `BBSS_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accept without busy")
   // results only come out of work started while busy
   `BBSS_ASSERT(a_strobe_after_busy, clock, reset, rsp_strobe |-> $past(busy), "stray result")
   // a dumped byte is only flagged on a real result
   `BBSS_ASSERT(a_has_needs_strobe, clock, reset, rsp_has_char |-> rsp_strobe, "has_char no strobe")
   // only dump bytes can be non-final results
   `BBSS_ASSERT(a_mid_has_char, clock, reset, (rsp_strobe && !rsp_last) |-> rsp_has_char,
      "non-final result without byte")

endmodule
